/* rtl/core/crr_pkg.sv */
// shared constants, codes and types for the chained range remapper
package crr_pkg;

   localparam int STAGES = 8;
   localparam int SLOTS  = 16;

   localparam int STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int SLT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(STAGES + 1);
   localparam int CFG_W  = 4;
   localparam int DATA_W = 32;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(7);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_XLATE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // window kept as [lo, hi) plus the offset added on a hit
   typedef struct packed {
      logic [DATA_W:0]   hi;
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] offset;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic             start;
      logic             step;
      logic             out_load;
      logic [STG_W-1:0] stage;
      logic [STG_W-1:0] rd_stage;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

/* rtl/core/crr_if.sv */
// handshake channel interfaces: request, response and csr write
interface crr_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [2:0]                stage_sel;
   logic [3:0]                slot_sel;
   logic                      entry_enable;
   logic [crr_pkg::DATA_W-1:0] dest_base;
   logic [crr_pkg::DATA_W-1:0] src_base;
   logic [crr_pkg::DATA_W-1:0] span_len;
   logic [crr_pkg::DATA_W-1:0] value_in;

   modport source (output valid, operation, stage_sel, slot_sel, entry_enable,
                   dest_base, src_base, span_len, value_in, input ready);
   modport sink   (input valid, operation, stage_sel, slot_sel, entry_enable,
                   dest_base, src_base, span_len, value_in, output ready);
endinterface

interface crr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [crr_pkg::DATA_W-1:0] mapped_value;

   modport source (output valid, mapped_value, input ready);
   modport sink   (input valid, mapped_value, output ready);
endinterface

interface crr_csr_if;
   logic                     valid;
   logic                     ready;
   logic [crr_pkg::CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/crr_ram.sv */
// generic single write port ram with registered read
module crr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/crr_ctrl.sv */
// controller: stage walk sequencer and the stages_in_use register
module crr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_operation,
   output logic                     req_ready,
   input  logic                     csr_valid,
   input  logic [crr_pkg::CFG_W-1:0] csr_data,
   input  crr_pkg::status_type      status,
   output crr_pkg::cmd_type         cmd
);
   crr_pkg::state_type          state_ff, state_in;
   logic [crr_pkg::CFG_W-1:0]   stages_ff;
   logic [crr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [crr_pkg::CNT_W-1:0]   cnt_next;
   logic [crr_pkg::CNT_W-1:0]   n_eff;

   // saturate at the number of built stages
   assign n_eff = (32'(stages_ff) > 32'(crr_pkg::STAGES)) ?
                  crr_pkg::CNT_W'(crr_pkg::STAGES) : crr_pkg::CNT_W'(stages_ff);
   assign cnt_next = cnt_ff + crr_pkg::CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= crr_pkg::ST_IDLE;
         stages_ff <= crr_pkg::CFG_RESET;
         cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_valid) begin
            stages_ff <= csr_data;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.stage    = crr_pkg::STG_W'(cnt_ff);
      cmd.rd_stage = '0;
      case (state_ff)
         crr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == crr_pkg::OP_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  cnt_in    = '0;
                  if (n_eff == '0) begin
                     state_in = crr_pkg::ST_FINISH;
                  end else begin
                     state_in = crr_pkg::ST_WALK;
                  end
               end
            end
         end
         crr_pkg::ST_WALK: begin
            cmd.step     = 1'b1;
            cmd.rd_stage = crr_pkg::STG_W'(cnt_next);
            cnt_in       = cnt_next;
            if (cnt_next == n_eff) begin
               if (!status.out_busy) begin
                  cmd.out_load = 1'b1;
                  state_in     = crr_pkg::ST_IDLE;
               end else begin
                  state_in = crr_pkg::ST_FINISH;
               end
            end
         end
         crr_pkg::ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = crr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crr_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

/* rtl/core/crr_datapath.sv */
// datapath: slot tables, valid flags, per-stage match and output register
module crr_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  crr_pkg::cmd_type          cmd,
   output crr_pkg::status_type       status,
   input  logic [2:0]                stage_sel,
   input  logic [3:0]                slot_sel,
   input  logic                      entry_enable,
   input  logic [crr_pkg::DATA_W-1:0] dest_base,
   input  logic [crr_pkg::DATA_W-1:0] src_base,
   input  logic [crr_pkg::DATA_W-1:0] span_len,
   input  logic [crr_pkg::DATA_W-1:0] value_in,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [crr_pkg::DATA_W-1:0] mapped_value
);
   logic [crr_pkg::SLOTS-1:0]   valid_ff [crr_pkg::STAGES];
   logic [crr_pkg::DATA_W-1:0]  value_ff;
   logic [crr_pkg::DATA_W-1:0]  out_data_ff;
   logic                        out_valid_ff;

   logic [crr_pkg::STG_W-1:0]   wr_stage;
   logic [crr_pkg::SLT_W-1:0]   wr_slot;
   logic                        wr_ok;
   crr_pkg::entry_type          wr_entry;
   crr_pkg::entry_type          rd_entry [crr_pkg::SLOTS];
   logic [crr_pkg::SLOTS-1:0]   row_valid;
   logic [crr_pkg::SLOTS-1:0]   hit;
   logic                        found;
   logic [crr_pkg::DATA_W-1:0]  hit_offset;
   logic [crr_pkg::DATA_W-1:0]  stepped;

   assign wr_stage = crr_pkg::STG_W'(stage_sel);
   assign wr_slot  = crr_pkg::SLT_W'(slot_sel);
   assign wr_ok    = cmd.wr_en &&
                     (32'(stage_sel) < 32'(crr_pkg::STAGES)) &&
                     (32'(slot_sel) < 32'(crr_pkg::SLOTS));

   assign wr_entry.lo     = src_base;
   assign wr_entry.hi     = {1'b0, src_base} + {1'b0, span_len};
   assign wr_entry.offset = dest_base - src_base;

   // one ram per slot, addressed by stage, so a whole stage reads at once
   for (genvar k = 0; k < crr_pkg::SLOTS; k++) begin : g_slot
      crr_ram #(
         .WIDTH ($bits(crr_pkg::entry_type)),
         .DEPTH (crr_pkg::STAGES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_ok && (wr_slot == crr_pkg::SLT_W'(k))),
         .wr_addr (wr_stage),
         .wr_data (wr_entry),
         .rd_addr (cmd.rd_stage),
         .rd_data (rd_entry[k])
      );
   end

   assign row_valid = valid_ff[cmd.stage];

   always_comb begin
      found      = 1'b0;
      hit_offset = '0;
      for (int k = 0; k < crr_pkg::SLOTS; k++) begin
         hit[k] = row_valid[k] && (value_ff >= rd_entry[k].lo) &&
                  ({1'b0, value_ff} < rd_entry[k].hi);
      end
      // lowest slot wins
      for (int k = crr_pkg::SLOTS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            found      = 1'b1;
            hit_offset = rd_entry[k].offset;
         end
      end
      stepped = found ? (value_ff + hit_offset) : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < crr_pkg::STAGES; s++) begin
            valid_ff[s] <= '0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         if (wr_ok) begin
            valid_ff[wr_stage][wr_slot] <= entry_enable;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         value_ff <= value_in;
      end else if (cmd.step) begin
         value_ff <= stepped;
      end
      if (cmd.out_load) begin
         out_data_ff <= cmd.step ? stepped : value_ff;
      end
   end

   assign status.out_busy = out_valid_ff && !rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign mapped_value    = out_data_ff;
endmodule

/* rtl/core/chained_range_remap.sv */
// top level of the chained range remapper
//
// channel   role    transfer carries
// req_if    sink    operation, stage_sel, slot_sel, entry_enable, bases, span_len, value_in
// rsp_if    source  mapped_value, one per translate
// csr_if    sink    stages_in_use (4 bits), always ready
//
// a table write keeps the block idle: the next request transfer can follow at once
// a translate reads stage 0 from the slot rams, then compares stages 0 to n - 1 in turn,
//   n = stages_in_use saturated at STAGES; with n = 0 the value passes through unchanged
// the slot rams' single read port sets the one-stage-per-cycle walk
// reset is synchronous, clears the valid flags and state and sets stages_in_use to 7
// a result waiting in the output register stalls only the end of the next translate
module chained_range_remap (
   input  logic      clock,
   input  logic      reset,
   crr_req_if.sink   req_if,
   crr_rsp_if.source rsp_if,
   crr_csr_if.sink   csr_if
);
   crr_pkg::cmd_type    cmd;
   crr_pkg::status_type status;

   // config register has no back pressure
   assign csr_if.ready = 1'b1;

   // sequencer: accepts requests only between translates
   crr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_operation (req_if.operation),
      .req_ready     (req_if.ready),
      .csr_valid     (csr_if.valid),
      .csr_data      (csr_if.data),
      .status        (status),
      .cmd           (cmd)
   );

   // tables, stage compare and the response register
   crr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .stage_sel    (req_if.stage_sel),
      .slot_sel     (req_if.slot_sel),
      .entry_enable (req_if.entry_enable),
      .dest_base    (req_if.dest_base),
      .src_base     (req_if.src_base),
      .span_len     (req_if.span_len),
      .value_in     (req_if.value_in),
      .rsp_ready    (rsp_if.ready),
      .rsp_valid    (rsp_if.valid),
      .mapped_value (rsp_if.mapped_value)
   );

   // never overwrite a response that has not been transferred
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !status.out_busy)
      else $error("output register loaded while response is stalled");

   // table writes only happen outside a stage walk
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && (cmd.step || cmd.out_load)))
      else $error("table write during translate");

   // a translate holds off the next request in the cycle after it is accepted
   a_xlate_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.operation == crr_pkg::OP_XLATE))
      |=> !req_if.ready)
      else $error("request accepted while translate in progress");

   // after a table write the block is ready again in the next cycle
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && (req_if.operation == crr_pkg::OP_WRITE))
      |=> req_if.ready)
      else $error("not ready after table write");
endmodule

/* dv/tb_top.sv */
// testbench for chained_range_remap: table writes and chained translates checked by a predictor
`timescale 1ns / 1ps

module tb_top;
   import crr_pkg::*;

   // one request transfer, every field driven whatever the operation
   typedef struct packed {
      op_type            operation;
      logic [2:0]        stage_sel;
      logic [3:0]        slot_sel;
      logic              entry_enable;
      logic [DATA_W-1:0] dest_base;
      logic [DATA_W-1:0] src_base;
      logic [DATA_W-1:0] span_len;
      logic [DATA_W-1:0] value_in;
   } remap_cmd_t;

   // shadow of the window tables plus the queue of mapped values still owed
   class remap_scoreboard;
      bit                win_on   [STAGES][SLOTS];
      logic [DATA_W-1:0] win_dest [STAGES][SLOTS];
      logic [DATA_W-1:0] win_src  [STAGES][SLOTS];
      logic [DATA_W-1:0] win_len  [STAGES][SLOTS];
      logic [CFG_W-1:0]  stage_count;
      logic [DATA_W-1:0] mapped_q [$];
      int                mismatches;

      function new();
         foreach (win_on[s, k]) win_on[s][k] = 1'b0;
         stage_count = CFG_RESET;
         mismatches  = 0;
      endfunction

      function void set_stages(logic [CFG_W-1:0] n);
         stage_count = n;
      endfunction

      function int pending();
         return mapped_q.size();
      endfunction

      // walk the enabled stages, lowest valid slot holding the value wins
      function logic [DATA_W-1:0] remap_chain(logic [DATA_W-1:0] v);
         int n;
         bit hit;
         n = (stage_count > STAGES) ? STAGES : stage_count;
         for (int s = 0; s < n; s++) begin
            hit = 1'b0;
            for (int k = 0; k < SLOTS && !hit; k++) begin
               // window end taken at 33 bits, so it never wraps
               if (win_on[s][k] && v >= win_src[s][k] &&
                   {1'b0, v} < {1'b0, win_src[s][k]} + {1'b0, win_len[s][k]}) begin
                  v   = win_dest[s][k] + (v - win_src[s][k]);
                  hit = 1'b1;
               end
            end
         end
         return v;
      endfunction

      function void note_request(remap_cmd_t c);
         if (c.operation == OP_WRITE) begin
            win_on[c.stage_sel][c.slot_sel]   = c.entry_enable;
            win_dest[c.stage_sel][c.slot_sel] = c.dest_base;
            win_src[c.stage_sel][c.slot_sel]  = c.src_base;
            win_len[c.stage_sel][c.slot_sel]  = c.span_len;
         end else begin
            mapped_q = {mapped_q, remap_chain(c.value_in)};
         end
      endfunction

      function void check_result(logic [DATA_W-1:0] got);
         logic [DATA_W-1:0] want;
         if (mapped_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: mapped_value %h", got);
         end else begin
            want = mapped_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mapped_value mismatch: expected %h, actual %h", want, got);
            end
         end
      endfunction

      // a value inside some valid window of one stage, if there is one
      function bit pick_hit_value(int stg, output logic [DATA_W-1:0] v);
         int                cand [$];
         int                k;
         logic [DATA_W-1:0] top;
         v = '0;
         for (int j = 0; j < SLOTS; j++)
            if (win_on[stg][j] && win_len[stg][j] != 0) cand = {cand, j};
         if (cand.size() == 0) return 1'b0;
         k   = cand[$urandom_range(0, cand.size() - 1)];
         top = (win_len[stg][k] - 1 < ~win_src[stg][k]) ? win_len[stg][k] - 1
                                                          : ~win_src[stg][k];
         v   = win_src[stg][k] + $urandom_range(0, top);
         return 1'b1;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;   // no idling on either side while set

   remap_scoreboard sb;

   crr_req_if req_if ();
   crr_rsp_if rsp_if ();
   crr_csr_if csr_if ();

   chained_range_remap DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls about 14 times in a hundred while calm is clear
   always @(negedge clock) begin
      rsp_if.ready = calm || ($urandom_range(0, 99) >= 14);
   end

   // every result transfer is checked against the oldest owed value
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         sb.check_result(rsp_if.mapped_value);
   end

   // addresses mostly clustered in four regions so windows of successive stages line up
   function automatic logic [DATA_W-1:0] pick_addr();
      logic [DATA_W-1:0] region [4] = '{32'h0000_0000, 32'h1000_0000,
                                        32'h8000_0000, 32'hFFFF_C000};
      if ($urandom_range(0, 9) < 3) return $urandom;
      return region[$urandom_range(0, 3)] + $urandom_range(0, 16383);
   endfunction

   function automatic logic [DATA_W-1:0] pick_span();
      case ($urandom_range(0, 19))
         0:       return '0;                                   // never matches
         1, 2:    return $urandom;
         3:       return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
         default: return $urandom_range(1, 16384);
      endcase
   endfunction

   // all fields random, unused ones included
   function automatic remap_cmd_t rand_cmd();
      remap_cmd_t c;
      c.operation    = $urandom_range(0, 1) ? OP_XLATE : OP_WRITE;
      c.stage_sel    = 3'($urandom);
      c.slot_sel     = 4'($urandom);
      c.entry_enable = 1'($urandom);
      c.dest_base    = $urandom;
      c.src_base     = $urandom;
      c.span_len     = $urandom;
      c.value_in     = $urandom;
      return c;
   endfunction

   function automatic remap_cmd_t rand_write();
      remap_cmd_t c;
      c              = rand_cmd();
      c.operation    = OP_WRITE;
      c.entry_enable = ($urandom_range(0, 3) != 0);
      c.dest_base    = pick_addr();
      c.src_base     = pick_addr();
      c.span_len     = pick_span();
      return c;
   endfunction

   function automatic remap_cmd_t rand_xlate();
      remap_cmd_t        c;
      logic [DATA_W-1:0] v;
      bit                hit;
      c         = rand_cmd();
      c.operation = OP_XLATE;
      hit       = 1'b0;
      // half the time aim inside a live window, usually one of stage 0
      if ($urandom_range(0, 9) < 5)
         hit = sb.pick_hit_value(($urandom_range(0, 3) == 0) ?
                                 $urandom_range(0, STAGES - 1) : 0, v);
      c.value_in = hit ? v : pick_addr();
      return c;
   endfunction

   function automatic remap_cmd_t mk_write(int stg, int slt, bit en, logic [DATA_W-1:0] dst,
                                           logic [DATA_W-1:0] src, logic [DATA_W-1:0] len);
      remap_cmd_t c;
      c              = rand_cmd();
      c.operation    = OP_WRITE;
      c.stage_sel    = 3'(stg);
      c.slot_sel     = 4'(slt);
      c.entry_enable = en;
      c.dest_base    = dst;
      c.src_base     = src;
      c.span_len     = len;
      return c;
   endfunction

   function automatic remap_cmd_t mk_xlate(logic [DATA_W-1:0] v);
      remap_cmd_t c;
      c           = rand_cmd();
      c.operation = OP_XLATE;
      c.value_in  = v;
      return c;
   endfunction

   // drive one request at the falling edge, note it once the transfer happens
   // leaves valid high, so back-to-back requests drop it only in a random idle gap
   task automatic send_cmd(input remap_cmd_t c);
      while (!calm && $urandom_range(0, 99) < 14) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.operation    = c.operation;
      req_if.stage_sel    = c.stage_sel;
      req_if.slot_sel     = c.slot_sel;
      req_if.entry_enable = c.entry_enable;
      req_if.dest_base    = c.dest_base;
      req_if.src_base     = c.src_base;
      req_if.span_len     = c.span_len;
      req_if.value_in     = c.value_in;
      req_if.valid        = 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(c);
      @(negedge clock);
   endtask

   // hold the sender until every owed result has come back
   task automatic drain();
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // stage count changes only with the block idle
   task automatic write_stages(input logic [CFG_W-1:0] n);
      drain();
      repeat (STAGES + 4) @(negedge clock);
      csr_if.data  = n;
      csr_if.valid = 1'b1;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      sb.set_stages(n);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   initial begin
      remap_cmd_t       c;
      logic [CFG_W-1:0] plan [7] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd8, 4'd3};

      sb                  = new();
      req_if.valid        = 1'b0;
      req_if.operation    = OP_WRITE;
      req_if.stage_sel    = '0;
      req_if.slot_sel     = '0;
      req_if.entry_enable = 1'b0;
      req_if.dest_base    = '0;
      req_if.src_base     = '0;
      req_if.span_len     = '0;
      req_if.value_in     = '0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.data         = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill every slot with a disabled window first so no translate ever
      // compares against a slot that was never written
      for (int s = 0; s < STAGES; s++)
         for (int k = 0; k < SLOTS; k++) begin
            c              = rand_write();
            c.stage_sel    = 3'(s);
            c.slot_sel     = 4'(k);
            c.entry_enable = 1'b0;
            send_cmd(c);
         end

      // directed part, reset stage count of 7
      // overlapping windows in stage 0: lower slot wins
      send_cmd(mk_write(0, 1, 1, 32'h0000_2000, 32'h0000_0100, 32'h10));
      send_cmd(mk_write(0, 0, 1, 32'h0000_3000, 32'h0000_0108, 32'h10));
      send_cmd(mk_xlate(32'h0000_0100));
      send_cmd(mk_xlate(32'h0000_0108));
      send_cmd(mk_xlate(32'h0000_0117));
      send_cmd(mk_xlate(32'h0000_0118));            // just past the window
      // zero length window never matches
      send_cmd(mk_write(0, 2, 1, 32'h0000_5000, 32'h0, 32'h0));
      send_cmd(mk_xlate(32'h0));
      // window running past the top of the range is cut at all ones
      send_cmd(mk_write(1, 3, 1, 32'h0000_0010, 32'hFFFF_FF00, 32'hFFFF_FFFF));
      send_cmd(mk_xlate(32'hFFFF_FFFF));
      send_cmd(mk_xlate(32'hFFFF_FEFF));
      // destination near the top so the result wraps
      send_cmd(mk_write(2, 0, 1, 32'hFFFF_FFF0, 32'h0000_2000, 32'h100));
      send_cmd(mk_xlate(32'h0000_0100));            // chained through stage 0 and 2
      send_cmd(mk_xlate(32'h0000_2020));
      // disabling write still stores fields, but the slot drops out
      send_cmd(mk_write(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_cmd(mk_xlate(32'h0000_0108));
      // highest stage and slot, unused at this stage count
      send_cmd(mk_write(7, 15, 1, 32'h0, 32'h0, 32'hFFFF_FFFF));
      send_cmd(mk_xlate(32'h0000_0005));
      send_cmd(mk_write(6, 15, 1, 32'hFFFF_FFFF, 32'h0, 32'h1));
      send_cmd(mk_xlate(32'h0));

      // random phases, one stage count each, zero and saturating counts included
      for (int p = 0; p < 7; p++) begin
         write_stages(plan[p]);
         calm = (p == 5);
         for (int i = 0; i < 250; i++) begin
            if (p == 2 && i == 125) drain();
            send_cmd(($urandom_range(0, 99) < 35) ? rand_write() : rand_xlate());
         end
         calm = 1'b0;
      end

      drain();
      repeat (STAGES + 4) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/crr_pkg.sv
rtl/core/crr_if.sv
rtl/core/crr_ram.sv
rtl/core/crr_ctrl.sv
rtl/core/crr_datapath.sv
rtl/core/chained_range_remap.sv
dv/tb_top.sv
